// ===== rtl/sedd_pkg.sv =====
// Package for the serpentine error-diffusion dither: field widths, error and
// level constants, the queued item type and the small arithmetic helpers.
// No dependencies; every other file of the block imports it.
package sedd_pkg;

  localparam int PIX_W     = 8;
  localparam int NCH       = 3;
  localparam int ERR_W     = 12;
  localparam int V_W       = 14;
  localparam int WIDE_W    = 18;
  localparam int IDX_W     = 5;
  localparam int COL_OUT_W = 12;
  localparam int CFG_W     = 13;

  localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(1024);

  localparam int QUEUE_DEPTH = 2;

  // Channel slots inside a packed pixel or error triple.
  localparam int CH_R = 2;
  localparam int CH_G = 1;
  localparam int CH_B = 0;

  // Quantizer thresholds and reconstructed values.
  localparam logic signed [V_W-1:0] LVL1_MIN = V_W'(64);
  localparam logic signed [V_W-1:0] LVL2_MIN = V_W'(191);
  localparam logic signed [V_W-1:0] QV_MID   = V_W'(127);
  localparam logic signed [V_W-1:0] QV_TOP   = V_W'(255);

  typedef logic [1:0] lvl_t;
  localparam lvl_t LVL_ZERO = 2'd0;
  localparam lvl_t LVL_MID  = 2'd1;
  localparam lvl_t LVL_TOP  = 2'd2;

  localparam int CUBE_R_WT = 9;
  localparam int CUBE_G_WT = 3;

  // Diffusion weights in sixteenths.
  localparam logic signed [WIDE_W-1:0] WT_AHEAD  = WIDE_W'(7);
  localparam logic signed [WIDE_W-1:0] WT_BELOW  = WIDE_W'(5);
  localparam logic signed [WIDE_W-1:0] WT_BEHIND = WIDE_W'(3);
  localparam logic signed [WIDE_W-1:0] WT_DIAG   = WIDE_W'(1);

  localparam logic signed [WIDE_W-1:0] ERR_HI = WIDE_W'(2 ** (ERR_W - 1) - 1);
  localparam logic signed [WIDE_W-1:0] ERR_LO = -(WIDE_W'(2 ** (ERR_W - 1)));

  typedef logic signed [ERR_W-1:0] err_t;
  typedef err_t [NCH-1:0] err3_t;
  typedef logic [NCH-1:0][PIX_W-1:0] pix3_t;

  // One classified pixel as it travels from the front to the back.
  // row_first marks the first pixel done in a row (no behind-below column);
  // row_restart marks a row position of zero, where no error is carried.
  typedef struct packed {
    pix3_t pix;
    logic  row_first;
    logic  row_restart;
    logic  last;
    logic  row_odd;
    logic  first_row;
  } fe_item_t;

  function automatic err_t sat_err(input logic signed [WIDE_W-1:0] v);
    err_t r;
    if (v > ERR_HI) begin
      r = ERR_HI[ERR_W-1:0];
    end else if (v < ERR_LO) begin
      r = ERR_LO[ERR_W-1:0];
    end else begin
      r = v[ERR_W-1:0];
    end
    return r;
  endfunction

  // Weighted error, divided by 16 rounding toward minus infinity.
  function automatic logic signed [WIDE_W-1:0] spread(input logic signed [WIDE_W-1:0] e,
                                                       input logic signed [WIDE_W-1:0] wt);
    logic signed [WIDE_W-1:0] p;
    p = e * wt;
    return p >>> 4;
  endfunction

  function automatic lvl_t quantize(input logic signed [V_W-1:0] v);
    lvl_t l;
    if (v >= LVL2_MIN) begin
      l = LVL_TOP;
    end else if (v >= LVL1_MIN) begin
      l = LVL_MID;
    end else begin
      l = LVL_ZERO;
    end
    return l;
  endfunction

  function automatic logic [IDX_W-1:0] cube_index(input lvl_t r, input lvl_t g, input lvl_t b);
    return IDX_W'(IDX_W'(r) * IDX_W'(CUBE_R_WT) + IDX_W'(g) * IDX_W'(CUBE_G_WT) + IDX_W'(b));
  endfunction

endpackage

// ===== rtl/sedd_if.sv =====
// Valid/ready channel interfaces of the dither: pixel input and palette result.
// Depends on sedd_pkg for the field widths.
interface sedd_in_if import sedd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] blue;
  logic             image_start;

  modport source (output valid, red, green, blue, image_start, input ready);
  modport sink   (input valid, red, green, blue, image_start, output ready);
endinterface

interface sedd_out_if import sedd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [IDX_W-1:0]     color_index;
  logic [COL_OUT_W-1:0] column;
  logic                 row_end;

  modport source (output valid, color_index, column, row_end, input ready);
  modport sink   (input valid, color_index, column, row_end, output ready);
endinterface

// ===== rtl/sedd_queue.sv =====
// Short FIFO between the front and the back of the dither.
// Depends on sedd_pkg for its depth; the entry width is a parameter.
module sedd_queue import sedd_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             valid
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign valid = (cnt_r != '0);
  assign rdata = entry_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= bump(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= bump(rd_ptr_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/sedd_front.sv =====
// Front of the dither: holds the width register, accepts pixel beats and tags
// each with its column, scan direction and row-edge flags. Depends on sedd_pkg
// and sedd_if.
module sedd_front import sedd_pkg::*; #(
  parameter int MAX_WIDTH = 4096,
  localparam int ADDR_W   = $clog2(MAX_WIDTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata,
  sedd_in_if.sink           in_pix,
  input  logic              busy,
  input  logic              q_full,
  output logic              q_push,
  output fe_item_t          q_item,
  output logic [ADDR_W-1:0] q_x
);

  logic [CFG_W-1:0]  width_r;
  logic [ADDR_W-1:0] col_pos_r, col_pos_nxt;
  logic              row_odd_r, row_odd_nxt;
  logic              first_row_r, first_row_nxt;

  logic [ADDR_W-1:0] wm1, col_cur, k;
  logic              odd_cur, first_cur, last;

  assign in_pix.ready = !q_full && !busy;
  assign q_push       = in_pix.valid && in_pix.ready;

  always_comb begin
    // Last column of the row, with the width register clamped to 1..MAX_WIDTH.
    if (width_r == '0) begin
      wm1 = '0;
    end else if (int'(width_r) > MAX_WIDTH) begin
      wm1 = ADDR_W'(MAX_WIDTH - 1);
    end else begin
      wm1 = ADDR_W'(width_r - CFG_W'(1));
    end

    col_cur   = in_pix.image_start ? '0 : col_pos_r;
    odd_cur   = in_pix.image_start ? 1'b0 : row_odd_r;
    first_cur = in_pix.image_start ? 1'b1 : first_row_r;

    // A width lowered mid-row makes this pixel end the row.
    k    = (col_cur > wm1) ? wm1 : col_cur;
    last = (k == wm1);
    q_x  = odd_cur ? k : (wm1 - k);

    q_item.pix[CH_R]   = in_pix.red;
    q_item.pix[CH_G]   = in_pix.green;
    q_item.pix[CH_B]   = in_pix.blue;
    q_item.row_first   = (k == '0);
    q_item.row_restart = (col_cur == '0);
    q_item.last        = last;
    q_item.row_odd     = odd_cur;
    q_item.first_row   = first_cur;

    if (last) begin
      col_pos_nxt   = '0;
      row_odd_nxt   = !odd_cur;
      first_row_nxt = 1'b0;
    end else begin
      col_pos_nxt   = k + ADDR_W'(1);
      row_odd_nxt   = odd_cur;
      first_row_nxt = first_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= WIDTH_RESET;
      col_pos_r   <= '0;
      row_odd_r   <= 1'b0;
      first_row_r <= 1'b1;
    end else begin
      if (cfg_we) begin
        width_r <= cfg_wdata;
      end
      if (q_push) begin
        col_pos_r   <= col_pos_nxt;
        row_odd_r   <= row_odd_nxt;
        first_row_r <= first_row_nxt;
      end
    end
  end

endmodule

// ===== rtl/sedd_back.sv =====
// Back of the dither: line store of next-row errors, quantizer, error spreading
// and the result register. Depends on sedd_pkg and sedd_if.
module sedd_back import sedd_pkg::*; #(
  parameter int MAX_WIDTH = 4096,
  localparam int ADDR_W   = $clog2(MAX_WIDTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  fe_item_t          q_item,
  input  logic [ADDR_W-1:0] q_x,
  output logic              q_pop,
  output logic              busy,
  sedd_out_if.source        out_res
);

  err3_t mem [MAX_WIDTH];

  // Clearing sweep after reset.
  logic              clr_active_r;
  logic [ADDR_W-1:0] clr_addr_r;

  // Working stage.
  logic              b2_valid_r;
  fe_item_t          b2_item_r;
  logic [ADDR_W-1:0] b2_x_r;
  err3_t             rd_data_r;
  logic              fwd_sel_r;
  err3_t             fwd_data_r;

  // Running error state.
  err3_t carry_r, blw0_r, blw1_r;
  err3_t carry_nxt, blw0_nxt, blw1_nxt;

  // Column finished at a row end, held until the write port is free.
  logic              ewr_v_r;
  logic [ADDR_W-1:0] ewr_addr_r;
  err3_t             ewr_data_r;

  logic                 out_valid_r;
  logic [IDX_W-1:0]     out_idx_r;
  logic [COL_OUT_W-1:0] out_col_r;
  logic                 out_end_r;

  logic              b2_adv, wa_en, fwd_hit;
  logic [ADDR_W-1:0] behind;
  err3_t             stored, carry_cur, blw0_cur, blw1_cur, wa_data, fwd_data;
  err3_t             mem_wdata;
  logic [ADDR_W-1:0] mem_waddr;
  logic              mem_we;

  logic signed [V_W-1:0]    v  [NCH];
  logic signed [V_W-1:0]    e  [NCH];
  logic signed [WIDE_W-1:0] ew [NCH];
  logic signed [WIDE_W-1:0] q7 [NCH];
  logic signed [WIDE_W-1:0] q5 [NCH];
  logic signed [WIDE_W-1:0] q3 [NCH];
  logic signed [WIDE_W-1:0] q1 [NCH];
  lvl_t                     lvl [NCH];

  assign busy   = clr_active_r;
  assign b2_adv = b2_valid_r && (!out_valid_r || out_res.ready);
  assign q_pop  = q_valid && (!b2_valid_r || b2_adv);
  assign behind = b2_item_r.row_odd ? (b2_x_r - ADDR_W'(1)) : (b2_x_r + ADDR_W'(1));
  assign wa_en  = b2_adv && !b2_item_r.row_first;

  assign out_res.valid       = out_valid_r;
  assign out_res.color_index = out_idx_r;
  assign out_res.column      = out_col_r;
  assign out_res.row_end     = out_end_r;

  always_comb begin
    if (b2_item_r.first_row) begin
      stored = '0;
    end else begin
      stored = fwd_sel_r ? fwd_data_r : rd_data_r;
    end
    // A row begun afresh (new row or image restart) has no carried error. A row
    // cut short by a lowered width keeps what the previous pixel left.
    carry_cur = b2_item_r.row_restart ? '0 : carry_r;
    blw0_cur  = b2_item_r.row_restart ? '0 : blw0_r;
    blw1_cur  = b2_item_r.row_restart ? '0 : blw1_r;

    for (int c = 0; c < NCH; c++) begin
      v[c] = V_W'($signed({1'b0, b2_item_r.pix[c]})) + V_W'($signed(carry_cur[c]))
           + V_W'($signed(stored[c]));
      lvl[c] = quantize(v[c]);
      case (lvl[c])
        LVL_TOP: e[c] = v[c] - QV_TOP;
        LVL_MID: e[c] = v[c] - QV_MID;
        default: e[c] = v[c];
      endcase
      ew[c] = WIDE_W'(e[c]);
      q7[c] = spread(ew[c], WT_AHEAD);
      q5[c] = spread(ew[c], WT_BELOW);
      q3[c] = spread(ew[c], WT_BEHIND);
      q1[c] = spread(ew[c], WT_DIAG);

      carry_nxt[c] = b2_item_r.last ? '0 : sat_err(q7[c]);
      blw1_nxt[c]  = b2_item_r.last ? '0 : sat_err(q1[c]);
      blw0_nxt[c]  = sat_err(WIDE_W'($signed(blw1_cur[c])) + q5[c]);
      wa_data[c]   = sat_err(WIDE_W'($signed(blw0_cur[c])) + q3[c]);
    end
  end

  // The item being popped reads the store as it enters the working stage; columns
  // written at that same edge, or still held back, are forwarded instead.
  always_comb begin
    fwd_hit  = 1'b0;
    fwd_data = ewr_data_r;
    if (b2_adv && b2_item_r.last && (b2_x_r == q_x)) begin
      fwd_hit  = 1'b1;
      fwd_data = blw0_nxt;
    end else if (wa_en && (behind == q_x)) begin
      fwd_hit  = 1'b1;
      fwd_data = wa_data;
    end else if (ewr_v_r && (ewr_addr_r == q_x)) begin
      fwd_hit  = 1'b1;
      fwd_data = ewr_data_r;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr_r;
    mem_wdata = '0;
    if (wa_en) begin
      mem_we    = 1'b1;
      mem_waddr = behind;
      mem_wdata = wa_data;
    end else if (ewr_v_r) begin
      mem_we    = 1'b1;
      mem_waddr = ewr_addr_r;
      mem_wdata = ewr_data_r;
    end else if (clr_active_r) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (q_pop) begin
      rd_data_r <= mem[q_x];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      b2_valid_r   <= 1'b0;
      ewr_v_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (clr_active_r && !wa_en && !ewr_v_r) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_W'(MAX_WIDTH - 1)) begin
          clr_active_r <= 1'b0;
        end
      end
      if (q_pop) begin
        b2_valid_r <= 1'b1;
      end else if (b2_adv) begin
        b2_valid_r <= 1'b0;
      end
      if (b2_adv && b2_item_r.last) begin
        ewr_v_r <= 1'b1;
      end else if (!wa_en) begin
        ewr_v_r <= 1'b0;
      end
      if (b2_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b2_item_r  <= q_item;
      b2_x_r     <= q_x;
      fwd_sel_r  <= fwd_hit;
      fwd_data_r <= fwd_data;
    end
    if (b2_adv) begin
      carry_r   <= carry_nxt;
      blw0_r    <= blw0_nxt;
      blw1_r    <= blw1_nxt;
      out_idx_r <= cube_index(lvl[CH_R], lvl[CH_G], lvl[CH_B]);
      out_col_r <= COL_OUT_W'(b2_x_r);
      out_end_r <= b2_item_r.last;
      if (b2_item_r.last) begin
        ewr_addr_r <= b2_x_r;
        ewr_data_r <= blw0_nxt;
      end
    end
  end

endmodule

// ===== rtl/serpentine_error_diffusion_dither_top.sv =====
// Serpentine error-diffusion dither of RGB pixels to a 27-entry color cube.
// in_pix carries one pixel per beat (red, green, blue, image_start) in
// serpentine order: row 0 and every even row right to left, odd rows left to
// right. image_start on a beat begins a new image at row 0 with no error from
// above. out_res gives one beat per pixel: the palette index, the physical
// column and row_end on the last pixel of each row.
// cfg_we/cfg_wdata write the row width (1..MAX_WIDTH, reset 1024); write it
// only while no pixel is in flight.
// Throughput is one pixel per clock while out_res.ready is high: the quantizer
// and the carried 7/16 error form a loop through carry_r, and the line store has
// one read and one write port. A beat passes the queue, the working stage and
// the result register on its way to out_res.valid. After reset a sweep clears
// the line store, one column per cycle over all MAX_WIDTH columns; in_pix.ready
// stays low until it ends. If the receiver stalls, the result register holds
// and the queue and working stage fill, after which in_pix.ready drops.
// Depends on sedd_pkg, sedd_if, sedd_front, sedd_queue and sedd_back.
module serpentine_error_diffusion_dither_top import sedd_pkg::*; #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  sedd_in_if.sink          in_pix,
  sedd_out_if.source       out_res
);

  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int Q_W    = $bits(fe_item_t) + ADDR_W;

  logic              busy;
  logic              q_full, q_push, q_pop, q_valid;
  fe_item_t          fe_item, q_item;
  logic [ADDR_W-1:0] fe_x, q_x;
  logic [Q_W-1:0]    q_wdata, q_rdata;

  assign q_wdata = {fe_item, fe_x};
  assign q_item  = fe_item_t'(q_rdata[Q_W-1:ADDR_W]);
  assign q_x     = q_rdata[ADDR_W-1:0];

  sedd_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_pix    (in_pix),
    .busy      (busy),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (fe_item),
    .q_x       (fe_x)
  );

  sedd_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .valid (q_valid)
  );

  sedd_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_x     (q_x),
    .q_pop   (q_pop),
    .busy    (busy),
    .out_res (out_res)
  );

  // No pixel enters while the line store is being cleared.
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_pix.ready)
    else $error("pixel input open during line store clear");

  // Nothing can reach the output before the clear has finished.
  a_clear_no_output: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_res.valid)
    else $error("result beat during line store clear");

  // The back only takes from a queue that holds an item.
  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // A full queue must have closed the input on the same cycle.
  a_full_blocks_push: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push)
    else $error("push into a full queue");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for serpentine_error_diffusion_dither_top: pixel beats
// go in from a queue, and each palette beat is checked against an in-bench model.
// Depends on sedd_pkg, the sedd_in_if/sedd_out_if interfaces and the dither RTL.
module tb_top;
  import sedd_pkg::*;

  localparam int MAX_COLS   = 4096;
  localparam int SETTLE     = 8;
  localparam int HOLD_AT    = 300;
  localparam int HOLD_LEN   = 400;
  localparam int MAX_PRINTS = 100;
  localparam int LIMIT      = 400000;
  localparam int WIDTH_PLAN[14] = '{2, 4096, 5, 16, 8191, 1, 7, 33, 3, 0, 12, 64, 1024, 4};

  typedef enum int {TONE_UNIFORM, TONE_EDGES, TONE_FLAT, TONE_EXTREME} tone_t;

  typedef struct {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             image_start;
  } pixel_t;

  typedef struct {
    logic [IDX_W-1:0]     color_index;
    logic [COL_OUT_W-1:0] column;
    logic                 row_end;
  } palette_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  sedd_in_if  pix_if ();
  sedd_out_if res_if ();

  serpentine_error_diffusion_dither_top #(.MAX_WIDTH(MAX_COLS)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_pix    (pix_if),
    .out_res   (res_if)
  );

  always #5 clk = ~clk;

  pixel_t   pixel_q[$];
  palette_t palette_q[$];

  // Model state of the dither.
  int row_width = 1024;
  int line_err[MAX_COLS][3];
  int carry_err[3];
  int pend_here[3];
  int pend_ahead[3];
  int col_pos;
  bit odd_row;
  bit top_row = 1'b1;

  int errors;
  int prints;
  int pixels_sent;
  int results_seen;
  int row_ends;
  int width_writes;
  int cycles;
  int in_wait;
  bit in_burst;
  int out_wait;
  bit out_burst;
  logic rx_hold;
  logic hold_done;
  int hold_cnt;

  function automatic int clamp12(input int v);
    if (v > 2047) return 2047;
    if (v < -2048) return -2048;
    return v;
  endfunction

  function automatic void restart_row();
    col_pos = 0;
    for (int c = 0; c < 3; c++) begin
      carry_err[c]  = 0;
      pend_here[c]  = 0;
      pend_ahead[c] = 0;
    end
  endfunction

  // Works out the palette beat for one accepted pixel and advances the model.
  function automatic void dither_pixel(input pixel_t px);
    int   w, k, x, behind;
    int   v, e, qv;
    int   raw[3];
    lvl_t lvl[3];
    bit   last;
    palette_t res;
    w = (row_width < 1) ? 1 : ((row_width > MAX_COLS) ? MAX_COLS : row_width);
    if (px.image_start) begin
      restart_row();
      odd_row = 1'b0;
      top_row = 1'b1;
    end
    k = (col_pos > w - 1) ? w - 1 : col_pos;
    last = (k == w - 1);
    x = odd_row ? k : (w - 1 - k);
    behind = odd_row ? x - 1 : x + 1;
    raw[0] = px.red;
    raw[1] = px.green;
    raw[2] = px.blue;
    for (int c = 0; c < 3; c++) begin
      v = raw[c] + carry_err[c] + (top_row ? 0 : line_err[x][c]);
      if (v >= int'(LVL2_MIN)) begin
        lvl[c] = LVL_TOP;
        qv = int'(QV_TOP);
      end else if (v >= int'(LVL1_MIN)) begin
        lvl[c] = LVL_MID;
        qv = int'(QV_MID);
      end else begin
        lvl[c] = LVL_ZERO;
        qv = 0;
      end
      e = v - qv;
      // The behind-below column gets its last share from this pixel.
      if (k != 0) line_err[behind][c] = clamp12(pend_here[c] + ((e * 3) >>> 4));
      pend_here[c]  = clamp12(pend_ahead[c] + ((e * 5) >>> 4));
      pend_ahead[c] = last ? 0 : clamp12(e >>> 4);
      carry_err[c]  = last ? 0 : clamp12((e * 7) >>> 4);
      if (last) line_err[x][c] = pend_here[c];
    end
    res.color_index = IDX_W'(int'(lvl[0]) * CUBE_R_WT + int'(lvl[1]) * CUBE_G_WT + int'(lvl[2]));
    res.column      = COL_OUT_W'(x);
    res.row_end     = last;
    palette_q.push_back(res);
    if (last) begin
      restart_row();
      odd_row = !odd_row;
      top_row = 1'b0;
      row_ends++;
    end else begin
      col_pos = k + 1;
    end
  endfunction

  // Driver: launches pixel beats from the queue with a random gap per beat.
  always @(posedge clk) begin
    pixel_t nxt;
    if (!rst_n) begin
      pix_if.valid       <= 1'b0;
      pix_if.red         <= '0;
      pix_if.green       <= '0;
      pix_if.blue        <= '0;
      pix_if.image_start <= 1'b0;
      in_wait = 0;
    end else begin
      if (cfg_we) row_width = int'(cfg_wdata);
      if (pix_if.valid && pix_if.ready) begin
        nxt.red         = pix_if.red;
        nxt.green       = pix_if.green;
        nxt.blue        = pix_if.blue;
        nxt.image_start = pix_if.image_start;
        dither_pixel(nxt);
        pixels_sent++;
      end
      if (!pix_if.valid || pix_if.ready) begin
        if (in_wait > 0) begin
          in_wait--;
          pix_if.valid <= 1'b0;
        end else if (pixel_q.size() != 0) begin
          nxt = pixel_q.pop_front();
          pix_if.red         <= nxt.red;
          pix_if.green       <= nxt.green;
          pix_if.blue        <= nxt.blue;
          pix_if.image_start <= nxt.image_start;
          pix_if.valid       <= 1'b1;
          if ($urandom_range(0, 29) == 0) in_burst = !in_burst;
          in_wait = in_burst ? 0 : $urandom_range(0, 13);
        end else begin
          pix_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each palette beat and paces the ready.
  always @(posedge clk) begin
    palette_t want;
    if (!rst_n) begin
      res_if.ready <= 1'b0;
      out_wait = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        results_seen++;
        if (palette_q.size() == 0) begin
          errors++;
          if (prints < MAX_PRINTS) begin
            prints++;
            $display("%0t: unexpected palette beat: index %0d column %0d row_end %0b",
                     $time, res_if.color_index, res_if.column, res_if.row_end);
          end
        end else begin
          want = palette_q.pop_front();
          if (want.color_index !== res_if.color_index || want.column !== res_if.column ||
              want.row_end !== res_if.row_end) begin
            errors++;
            if (prints < MAX_PRINTS) begin
              prints++;
              $display("%0t: mismatch: expected index %0d column %0d row_end %0b, got index %0d column %0d row_end %0b",
                       $time, want.color_index, want.column, want.row_end,
                       res_if.color_index, res_if.column, res_if.row_end);
            end
          end
        end
        if ($urandom_range(0, 29) == 0) out_burst = !out_burst;
        out_wait = out_burst ? 0 : $urandom_range(0, 13);
      end else if (out_wait > 0) begin
        out_wait--;
      end
      res_if.ready <= !rx_hold && (out_wait == 0);
    end
  end

  // One long receiver stall so the block backs up and drops its input ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_hold   <= 1'b0;
      hold_done <= 1'b0;
      hold_cnt  <= 0;
    end else if (!rx_hold && !hold_done && results_seen >= HOLD_AT) begin
      rx_hold  <= 1'b1;
      hold_cnt <= 1;
    end else if (rx_hold) begin
      if (hold_cnt == HOLD_LEN) begin
        rx_hold   <= 1'b0;
        hold_done <= 1'b1;
      end else begin
        hold_cnt <= hold_cnt + 1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles, palette_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic add_pixel(input int r, input int g, input int b, input bit start);
    pixel_t px;
    px.red         = PIX_W'(r);
    px.green       = PIX_W'(g);
    px.blue        = PIX_W'(b);
    px.image_start = start;
    pixel_q.push_back(px);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pixel_q.size() != 0 || pix_if.valid || palette_q.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_width(input int w);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= CFG_W'(w);
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
    width_writes++;
  endtask

  function automatic int tone_value(input tone_t tone, input int base);
    int cuts[5] = '{0, 64, 127, 191, 255};
    int v;
    case (tone)
      TONE_EDGES:   v = cuts[$urandom_range(0, 4)] + $urandom_range(0, 6) - 3;
      TONE_FLAT:    v = base + $urandom_range(0, 8) - 4;
      TONE_EXTREME: v = $urandom_range(0, 1) ? 255 : 0;
      default:      v = $urandom_range(0, 255);
    endcase
    return (v < 0) ? 0 : ((v > 255) ? 255 : v);
  endfunction

  task automatic queue_random_pixels(input int count);
    tone_t tone;
    int    base[3];
    bit    start;
    tone = tone_t'($urandom_range(0, 3));
    for (int c = 0; c < 3; c++) base[c] = $urandom_range(0, 255);
    for (int i = 0; i < count; i++) begin
      start = (i == 0) ? bit'($urandom_range(0, 1)) : ($urandom_range(0, 63) == 0);
      add_pixel(tone_value(tone, base[0]), tone_value(tone, base[1]),
                tone_value(tone, base[2]), start);
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    pix_if.valid       = 1'b0;
    pix_if.red         = '0;
    pix_if.green       = '0;
    pix_if.blue        = '0;
    pix_if.image_start = 1'b0;
    res_if.ready       = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset width: extremes and quantizer thresholds on the first row.
    add_pixel(0, 0, 0, 1'b1);
    add_pixel(255, 255, 255, 1'b0);
    add_pixel(63, 64, 190, 1'b0);
    add_pixel(191, 127, 128, 1'b0);
    add_pixel(255, 0, 255, 1'b0);
    // Narrowing the row here saturates the position, so the next pixel ends the row.
    set_width(3);
    add_pixel(0, 0, 0, 1'b0);
    add_pixel(200, 100, 30, 1'b1);
    add_pixel(64, 63, 191, 1'b0);
    add_pixel(190, 255, 0, 1'b0);
    add_pixel(100, 150, 20, 1'b0);
    add_pixel(30, 180, 250, 1'b0);
    add_pixel(128, 128, 128, 1'b0);
    add_pixel(255, 62, 192, 1'b0);
    add_pixel(0, 65, 189, 1'b0);
    add_pixel(140, 40, 230, 1'b0);
    set_width(1);
    add_pixel(90, 170, 250, 1'b1);
    add_pixel(90, 170, 250, 1'b0);
    add_pixel(10, 120, 200, 1'b0);
    // A zero width behaves as a single column.
    set_width(0);
    add_pixel(250, 60, 130, 1'b0);
    add_pixel(5, 195, 66, 1'b0);

    foreach (WIDTH_PLAN[i]) begin
      set_width(WIDTH_PLAN[i]);
      queue_random_pixels($urandom_range(50, 85));
    end

    wait_idle();
    $display("covered %0d pixels and %0d row ends over %0d width settings,", pixels_sent,
             row_ends, width_writes);
    $display("with one receiver stall of %0d cycles and random gaps on both sides", HOLD_LEN);
    if (errors == 0 && palette_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
